// File: rtl/core/amsd_pkg.sv
// ----------------------------------------------------------------------------
// amsd_pkg: shared types and constants of the magnitude step detector
// Field widths, register indexes, reset values and the beat types that
// travel between the squaring unit, the square root unit and the top level.
// ----------------------------------------------------------------------------
package amsd_pkg;

   localparam int AXIS_W      = 14;  // sample, offset and absolute difference width
   localparam int SUM_W       = 30;  // sum of three squares
   localparam int MAG_W       = 15;  // magnitude and smoothed magnitude
   localparam int COUNT_W     = 16;  // wrapping step count
   localparam int THRESH_W    = 15;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 3;

   localparam logic [THRESH_W-1:0] STEP_THRESHOLD_RESET   = 15'd2500;
   localparam logic [THRESH_W-1:0] CHANGE_THRESHOLD_RESET = 15'd750;
   // Largest reachable magnitude: floor of the root of three full-scale squares.
   localparam logic [MAG_W-1:0]    MAG_MAX                = 15'd28376;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_OFFSET         = 3'd0,
      CSR_Y_OFFSET         = 3'd1,
      CSR_Z_OFFSET         = 3'd2,
      CSR_STEP_THRESHOLD   = 3'd3,
      CSR_CHANGE_THRESHOLD = 3'd4
   } csr_index_type;

   typedef logic [AXIS_W-1:0] axis_mag_type;

   // Absolute axis differences on their way into the squaring unit.
   typedef struct packed {
      logic                   valid;
      axis_mag_type [2:0]     mag;
   } operand_beat_type;

   // Sum of squares on its way into the square root unit.
   typedef struct packed {
      logic                   valid;
      logic [SUM_W-1:0]       sum;
   } sum_beat_type;

   // Vector magnitude on its way into the detector.
   typedef struct packed {
      logic                   valid;
      logic [MAG_W-1:0]       root;
   } mag_beat_type;

endpackage

// File: rtl/core/amsd_sqsum.sv
// ----------------------------------------------------------------------------
// amsd_sqsum: digit-serial sum of three squares
// Each axis magnitude multiplies itself two bits per cycle: the multiplier
// shifts right, the multiplicand shifts left, and the three partial products
// add into one accumulator. The result is held until the next unit takes it.
// ----------------------------------------------------------------------------
module amsd_sqsum (
   input  logic                        clock,
   input  logic                        reset,
   input  amsd_pkg::operand_beat_type  op_in,
   output logic                        op_ready,
   output amsd_pkg::sum_beat_type      sum_out,
   input  logic                        sum_ready
);
   import amsd_pkg::*;

   localparam int DIGITS = (AXIS_W + 1) / 2;
   localparam int CNT_W  = $clog2(DIGITS);
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_DONE
   } state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [2:0][AXIS_W-1:0]        mplier_ff;
   logic [2:0][SUM_W-1:0]         mcand_ff;
   logic [SUM_W-1:0]              acc_ff;

   logic [2:0][SUM_W-1:0]         term;
   logic [SUM_W-1:0]              acc_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (mplier_ff[k][1:0])
            2'd0:    term[k] = '0;
            2'd1:    term[k] = mcand_ff[k];
            2'd2:    term[k] = mcand_ff[k] << 1;
            default: term[k] = mcand_ff[k] + (mcand_ff[k] << 1);
         endcase
      end
   end

   assign acc_in = acc_ff + term[0] + term[1] + term[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (op_in.valid) begin
                  for (int k = 0; k < 3; k++) begin
                     mplier_ff[k] <= op_in.mag[k];
                     mcand_ff[k]  <= SUM_W'(op_in.mag[k]);
                  end
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_BUSY;
               end
            end
            S_BUSY: begin
               acc_ff <= acc_in;
               for (int k = 0; k < 3; k++) begin
                  mplier_ff[k] <= mplier_ff[k] >> 2;
                  mcand_ff[k]  <= mcand_ff[k] << 2;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_DIGIT) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (sum_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign op_ready      = (state_ff == S_IDLE);
   assign sum_out.valid = (state_ff == S_DONE);
   assign sum_out.sum   = acc_ff;

   // All multiplier digits must be used up once the sum is offered.
   a_digits_consumed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (mplier_ff == '0))
      else $error("squarer finished with multiplier digits left");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> (cnt_ff <= LAST_DIGIT))
      else $error("squarer digit count ran past the last digit");

endmodule

// File: rtl/core/amsd_isqrt.sv
// ----------------------------------------------------------------------------
// amsd_isqrt: digit-serial floor square root
// Restoring method: two radicand bits enter the partial remainder each cycle
// and one root bit is decided by a single trial subtraction.
// ----------------------------------------------------------------------------
module amsd_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  amsd_pkg::sum_beat_type  sum_in,
   output logic                    sum_ready,
   output amsd_pkg::mag_beat_type  mag_out,
   input  logic                    mag_ready
);
   import amsd_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);
   localparam int REM_W = MAG_W + 2;
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(MAG_W - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [SUM_W-1:0]     rad_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [MAG_W-1:0]     root_ff;

   logic [REM_W+1:0]     rem_shift;
   logic [REM_W+1:0]     trial;
   logic [REM_W+1:0]     rem_diff;
   logic                 take;
   logic [REM_W-1:0]     rem_in;
   logic [MAG_W-1:0]     root_in;

   assign rem_shift = {rem_ff, rad_ff[SUM_W-1 -: 2]};
   assign trial     = (REM_W + 2)'({root_ff, 2'b01});
   assign rem_diff  = rem_shift - trial;
   assign take      = (rem_shift >= trial);
   assign rem_in    = take ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
   assign root_in   = {root_ff[MAG_W-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (sum_in.valid) begin
                  rad_ff   <= sum_in.sum;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_BUSY;
               end
            end
            S_BUSY: begin
               rad_ff  <= rad_ff << 2;
               rem_ff  <= rem_in;
               root_ff <= root_in;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_DIGIT) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (mag_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sum_ready     = (state_ff == S_IDLE);
   assign mag_out.valid = (state_ff == S_DONE);
   assign mag_out.root  = root_ff;

   // The partial remainder never exceeds twice the partial root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> (rem_ff <= REM_W'({root_ff, 1'b0})))
      else $error("square root remainder out of bound");

   a_rad_consumed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (rad_ff == '0))
      else $error("square root finished with radicand bits left");

endmodule

// File: rtl/core/accel_magnitude_step_detector.sv
// ----------------------------------------------------------------------------
// accel_magnitude_step_detector: accelerometer step counter
// Offset-corrected vector magnitude, two-sample smoothing and a threshold
// detector with re-arm on a large change of the smoothed magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one beat per 3-axis sample; the rsp channel returns
//   exactly one beat per sample, in order, with the step count after that
//   sample, the smoothed magnitude and a flag that this sample counted a step.
//   The csr port writes offsets and thresholds; write it only while no sample
//   is in flight.
//   A sample passes from req acceptance through the squaring unit, the square
//   root unit and the rsp register to rsp_valid. The square root unit, one
//   root bit per cycle for 15 bits, sets the sustained rate; the squaring unit
//   (two multiplier bits a cycle) works on the next sample meanwhile.
//   Reset clears the offsets, loads the default thresholds, clears the step
//   count, the stored magnitude and average and the armed flag, and empties
//   all stages.
//   When the receiver stalls, the result waits in the rsp register, the root
//   unit holds its finished magnitude, and req_ready, low while the squaring
//   unit works, stays low once it also holds a finished sum.
// ----------------------------------------------------------------------------
module accel_magnitude_step_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [amsd_pkg::AXIS_W-1:0]  req_sample_x,
   input  logic signed [amsd_pkg::AXIS_W-1:0]  req_sample_y,
   input  logic signed [amsd_pkg::AXIS_W-1:0]  req_sample_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [amsd_pkg::COUNT_W-1:0]        rsp_step_count,
   output logic [amsd_pkg::MAG_W-1:0]          rsp_smoothed_magnitude,
   output logic                                rsp_step_seen,
   input  logic                                csr_wr_en,
   input  logic [amsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [amsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import amsd_pkg::*;

   logic signed [AXIS_W-1:0]  x_off_ff;
   logic signed [AXIS_W-1:0]  y_off_ff;
   logic signed [AXIS_W-1:0]  z_off_ff;
   logic [THRESH_W-1:0]       step_thr_ff;
   logic [THRESH_W-1:0]       chg_thr_ff;

   logic [MAG_W-1:0]          prev_mag_ff;
   logic [MAG_W-1:0]          prev_avg_ff;
   logic                      armed_ff;
   logic [COUNT_W-1:0]        steps_ff;

   logic                      rsp_valid_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic [MAG_W-1:0]          rsp_avg_ff;
   logic                      rsp_seen_ff;

   operand_beat_type          op_beat;
   logic                      op_ready;
   sum_beat_type              sum_beat;
   logic                      sum_ready;
   mag_beat_type              mag_beat;
   logic                      load_out;

   logic [MAG_W:0]            avg_sum;
   logic [MAG_W-1:0]          avg_in;
   logic [MAG_W-1:0]          change_in;
   logic                      seen_in;
   logic [COUNT_W-1:0]        steps_in;
   logic                      armed_in;

   // The difference spans -16383..16383, so its magnitude fits the axis width.
   function automatic axis_mag_type abs_diff(logic signed [AXIS_W-1:0] s,
                                             logic signed [AXIS_W-1:0] o);
      logic signed [AXIS_W:0] d;
      logic        [AXIS_W:0] a;
      d = {s[AXIS_W-1], s} - {o[AXIS_W-1], o};
      a = d[AXIS_W] ? (~d + 1'b1) : d;
      return a[AXIS_W-1:0];
   endfunction

   assign op_beat.valid  = req_valid;
   assign op_beat.mag[0] = abs_diff(req_sample_x, x_off_ff);
   assign op_beat.mag[1] = abs_diff(req_sample_y, y_off_ff);
   assign op_beat.mag[2] = abs_diff(req_sample_z, z_off_ff);
   assign req_ready      = op_ready;

   amsd_sqsum u_sqsum (
      .clock     (clock),
      .reset     (reset),
      .op_in     (op_beat),
      .op_ready  (op_ready),
      .sum_out   (sum_beat),
      .sum_ready (sum_ready)
   );

   amsd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .sum_in    (sum_beat),
      .sum_ready (sum_ready),
      .mag_out   (mag_beat),
      .mag_ready (load_out)
   );

   // Detector update happens only when the result register is free or is being emptied by rsp_ready.
   assign load_out = mag_beat.valid && (!rsp_valid_ff || rsp_ready);

   assign avg_sum   = {1'b0, mag_beat.root} + {1'b0, prev_mag_ff};
   assign avg_in    = avg_sum[MAG_W:1];
   assign change_in = (avg_in >= prev_avg_ff) ? (avg_in - prev_avg_ff)
                                              : (prev_avg_ff - avg_in);
   assign seen_in   = (avg_in > step_thr_ff) && !armed_ff;
   assign steps_in  = seen_in ? (steps_ff + 1'b1) : steps_ff;
   // A sample that arms the detector can disarm it again at once.
   assign armed_in  = (armed_ff || seen_in) && !(change_in > chg_thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff     <= '0;
         y_off_ff     <= '0;
         z_off_ff     <= '0;
         step_thr_ff  <= STEP_THRESHOLD_RESET;
         chg_thr_ff   <= CHANGE_THRESHOLD_RESET;
         prev_mag_ff  <= '0;
         prev_avg_ff  <= '0;
         armed_ff     <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_X_OFFSET:         x_off_ff    <= csr_wdata[AXIS_W-1:0];
               CSR_Y_OFFSET:         y_off_ff    <= csr_wdata[AXIS_W-1:0];
               CSR_Z_OFFSET:         z_off_ff    <= csr_wdata[AXIS_W-1:0];
               CSR_STEP_THRESHOLD:   step_thr_ff <= csr_wdata[THRESH_W-1:0];
               CSR_CHANGE_THRESHOLD: chg_thr_ff  <= csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (load_out) begin
            prev_mag_ff  <= mag_beat.root;
            prev_avg_ff  <= avg_in;
            armed_ff     <= armed_in;
            steps_ff     <= steps_in;
            rsp_count_ff <= steps_in;
            rsp_avg_ff   <= avg_in;
            rsp_seen_ff  <= seen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_step_count         = rsp_count_ff;
   assign rsp_smoothed_magnitude = rsp_avg_ff;
   assign rsp_step_seen          = rsp_seen_ff;

   // The step flag marks exactly the beats on which the count moved.
   a_seen_matches_count: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_step_seen == (rsp_step_count != $past(steps_ff))))
      else $error("step flag disagrees with step count");

   a_arm_needs_step: assert property (@(posedge clock) disable iff (reset)
      $rose(armed_ff) |-> $past(load_out && seen_in))
      else $error("detector armed without counting a step");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_smoothed_magnitude <= MAG_MAX))
      else $error("smoothed magnitude above reachable maximum");

endmodule

// File: tb/tb_accel_magnitude_step_detector.sv
// ----------------------------------------------------------------------------
// tb_accel_magnitude_step_detector: self-checking bench for the step detector
// Samples go in through a queue-fed driver, and a monitor predicts each
// result from its own copy of the offsets, thresholds and detector state.
// Directed samples cover the extremes first. A short run of back-to-back
// steps without idle gaps follows, then random rounds with walking-like
// magnitude patterns, each under its own register setting.
// ----------------------------------------------------------------------------
module tb_accel_magnitude_step_detector;
   import amsd_pkg::*;

   typedef struct packed {
      logic [AXIS_W-1:0] x;
      logic [AXIS_W-1:0] y;
      logic [AXIS_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic [COUNT_W-1:0] step_count;
      logic [MAG_W-1:0]   smoothed_magnitude;
      logic               step_seen;
   } step_result_type;

   localparam int RANDOM_ROUNDS   = 6;
   localparam int ROUND_SAMPLES   = 230;
   localparam int PRINT_CAP       = 25;
   localparam int DRAIN_CYCLES    = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [AXIS_W-1:0] req_sample_x = '0;
   logic signed [AXIS_W-1:0] req_sample_y = '0;
   logic signed [AXIS_W-1:0] req_sample_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_W-1:0]       rsp_step_count;
   logic [MAG_W-1:0]         rsp_smoothed_magnitude;
   logic                     rsp_step_seen;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   sample_type      pending_samples[$];
   step_result_type expected_steps[$];

   // Predicted detector state and register copies.
   logic [AXIS_W-1:0]   cfg_x_offset;
   logic [AXIS_W-1:0]   cfg_y_offset;
   logic [AXIS_W-1:0]   cfg_z_offset;
   logic [THRESH_W-1:0] cfg_step_threshold;
   logic [THRESH_W-1:0] cfg_change_threshold;
   logic [MAG_W-1:0]    last_magnitude;
   logic [MAG_W-1:0]    last_average;
   logic                armed;
   logic [COUNT_W-1:0]  step_total;

   logic            req_accepted = 1'b0;
   bit              idle_on = 1'b1;
   int              send_gap = 0;
   int              stall_left = 0;
   int              error_count = 0;
   int              samples_accepted = 0;
   int              results_checked = 0;
   int              steps_flagged = 0;
   int              wrap_count = 0;
   int              settings_used = 0;
   step_result_type want;

   accel_magnitude_step_detector uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_sample_x           (req_sample_x),
      .req_sample_y           (req_sample_y),
      .req_sample_z           (req_sample_z),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_step_count         (rsp_step_count),
      .rsp_smoothed_magnitude (rsp_smoothed_magnitude),
      .rsp_step_seen          (rsp_step_seen),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic logic [AXIS_W-1:0] clamp_axis(input int v);
      if (v > 8191) return 14'h1FFF;
      if (v < -8192) return 14'h2000;
      return 14'(v);
   endfunction

   function automatic logic [SUM_W-1:0] axis_square(input logic [AXIS_W-1:0] sample,
                                                    input logic [AXIS_W-1:0] offset);
      int diff;
      diff = int'($signed(sample)) - int'($signed(offset));
      if (diff < 0) diff = -diff;
      return SUM_W'(diff * diff);
   endfunction

   // Builds the root from the top bit down, keeping each bit whose square still fits.
   function automatic logic [MAG_W-1:0] floor_root(input logic [SUM_W-1:0] value);
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] trial;
      root = '0;
      for (int bit_pos = MAG_W - 1; bit_pos >= 0; bit_pos--) begin
         trial = root;
         trial[bit_pos] = 1'b1;
         if (longint'(trial) * longint'(trial) <= longint'(value)) root = trial;
      end
      return root;
   endfunction

   function automatic step_result_type predict_step_result(input logic [AXIS_W-1:0] sx,
                                                           input logic [AXIS_W-1:0] sy,
                                                           input logic [AXIS_W-1:0] sz);
      logic [SUM_W-1:0] sum_sq;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] avg;
      logic [MAG_W-1:0] change;
      logic [MAG_W:0]   pair;
      step_result_type  r;
      sum_sq = axis_square(sx, cfg_x_offset) + axis_square(sy, cfg_y_offset)
             + axis_square(sz, cfg_z_offset);
      mag = floor_root(sum_sq);
      pair = {1'b0, mag} + {1'b0, last_magnitude};
      avg = pair[MAG_W:1];
      r.step_seen = 1'b0;
      if (avg > cfg_step_threshold && !armed) begin
         step_total = step_total + 1'b1;
         if (step_total == '0) wrap_count++;
         armed = 1'b1;
         r.step_seen = 1'b1;
      end
      // A sample that just armed may disarm again on the same large jump.
      change = (avg >= last_average) ? avg - last_average : last_average - avg;
      if (armed && change > cfg_change_threshold) armed = 1'b0;
      last_magnitude = mag;
      last_average = avg;
      r.step_count = step_total;
      r.smoothed_magnitude = avg;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint wanted);
      if (error_count < PRINT_CAP)
         $display("MISMATCH at result %0d: %s, got %0d, expected %0d",
                  results_checked, what, got, wanted);
      error_count++;
   endtask

   // Sample driver.
   always @(negedge clock) begin
      sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_accepted) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            s = pending_samples.pop_front();
            req_sample_x <= s.x;
            req_sample_y <= s.y;
            req_sample_z <= s.z;
            req_valid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // Monitor: tracks register writes, predicts on each accepted sample and
   // checks each result beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         req_accepted <= 1'b0;
         cfg_x_offset = '0;
         cfg_y_offset = '0;
         cfg_z_offset = '0;
         cfg_step_threshold = STEP_THRESHOLD_RESET;
         cfg_change_threshold = CHANGE_THRESHOLD_RESET;
         last_magnitude = '0;
         last_average = '0;
         armed = 1'b0;
         step_total = '0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_X_OFFSET:         cfg_x_offset = csr_wdata[AXIS_W-1:0];
               CSR_Y_OFFSET:         cfg_y_offset = csr_wdata[AXIS_W-1:0];
               CSR_Z_OFFSET:         cfg_z_offset = csr_wdata[AXIS_W-1:0];
               CSR_STEP_THRESHOLD:   cfg_step_threshold = csr_wdata;
               CSR_CHANGE_THRESHOLD: cfg_change_threshold = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_steps.push_back(predict_step_result(req_sample_x, req_sample_y,
                                                         req_sample_z));
            samples_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("result beat with no sample pending", rsp_step_count, -1);
            end else begin
               want = expected_steps.pop_front();
               if (rsp_step_count !== want.step_count)
                  report_mismatch("step_count", rsp_step_count, want.step_count);
               if (rsp_smoothed_magnitude !== want.smoothed_magnitude)
                  report_mismatch("smoothed_magnitude", rsp_smoothed_magnitude,
                                  want.smoothed_magnitude);
               if (rsp_step_seen !== want.step_seen)
                  report_mismatch("step_seen", rsp_step_seen, want.step_seen);
               if (want.step_seen) steps_flagged++;
            end
            results_checked++;
         end
      end
   end

   task automatic queue_sample(input int x, input int y, input int z);
      sample_type s;
      s.x = clamp_axis(x);
      s.y = clamp_axis(y);
      s.z = clamp_axis(z);
      pending_samples.push_back(s);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_until_idle();
      while (pending_samples.size() != 0 || req_valid || expected_steps.size() != 0)
         @(negedge clock);
   endtask

   // Walking-like stream: runs of peaks above the step threshold alternate
   // with quiet runs, with some fully random samples mixed in.
   task automatic queue_walk(input int count, input int xo, input int yo, input int zo,
                             input int thr, input int chg);
      int  m;
      int  run_left;
      int  sgn;
      bit  peak;
      run_left = 0;
      peak = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            peak = !peak;
            run_left = $urandom_range(1, 4);
         end
         run_left--;
         if ($urandom_range(0, 9) < 8) begin
            m = peak ? thr + int'($urandom_range(0, 2 * chg + 600))
                     : int'($urandom_range(0, thr / 2));
            sgn = $urandom_range(0, 1) ? 1 : -1;
            queue_sample(xo + sgn * m, yo + int'($urandom_range(0, 400)) - 200,
                         zo + int'($urandom_range(0, 400)) - 200);
         end else begin
            queue_sample(int'($signed(14'($urandom))), int'($signed(14'($urandom))),
                         int'($signed(14'($urandom))));
         end
      end
   endtask

   function automatic int pick_offset();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return $urandom_range(0, 1) ? 8191 : -8192;
         default: return int'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   function automatic int pick_threshold(input int usual_high);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32767;
         default: return $urandom_range(0, usual_high);
      endcase
   endfunction

   initial begin
      int xo;
      int yo;
      int zo;
      int thr;
      int chg;
      int burst_samples;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: first sample, full-scale vectors, a step that arms and
      // disarms on one sample, a step that stays armed, then a drop back.
      queue_sample(0, 0, 0);
      queue_sample(8191, 8191, 8191);
      queue_sample(-8192, -8192, -8192);
      queue_sample(-8192, -8192, -8192);
      queue_sample(-8192, -8192, -8192);
      queue_sample(0, 0, 0);
      queue_sample(0, 0, 0);
      queue_sample(8191, -8192, 1);
      queue_sample(-1, 0, 8191);
      wait_until_idle();

      // Offsets at the extremes give full-scale differences; bit 14 of the
      // x write must be dropped.
      write_csr(CSR_X_OFFSET, 15'h6000);
      write_csr(CSR_Y_OFFSET, 15'h1FFF);
      write_csr(CSR_Z_OFFSET, 15'h2000);
      write_csr(CSR_INDEX_W'(int'(CSR_CHANGE_THRESHOLD) + 1), 15'($urandom));
      write_csr(CSR_INDEX_W'($urandom_range(int'(CSR_CHANGE_THRESHOLD) + 1,
                                            (1 << CSR_INDEX_W) - 1)),
                15'($urandom));
      settings_used++;
      queue_sample(8191, -8192, 8191);
      queue_sample(8191, -8192, 8191);
      queue_sample(-8192, 8191, -8192);
      queue_sample(8191, 8191, -8192);
      wait_until_idle();

      // Zero thresholds: every changing nonzero average counts and disarms.
      write_csr(CSR_X_OFFSET, 15'd0);
      write_csr(CSR_Y_OFFSET, 15'd0);
      write_csr(CSR_Z_OFFSET, 15'd0);
      write_csr(CSR_STEP_THRESHOLD, 15'd0);
      write_csr(CSR_CHANGE_THRESHOLD, 15'd0);
      settings_used++;
      queue_sample(0, 0, 0);
      queue_sample(100, 0, 0);
      queue_sample(300, 0, 0);
      queue_sample(300, 0, 0);
      wait_until_idle();

      // Largest thresholds: no step can ever count.
      write_csr(CSR_STEP_THRESHOLD, 15'h7FFF);
      write_csr(CSR_CHANGE_THRESHOLD, 15'h7FFF);
      settings_used++;
      queue_sample(8191, 8191, 8191);
      queue_sample(-8192, -8192, -8192);
      queue_sample(0, 0, 0);
      wait_until_idle();

      // Back-to-back steps with zero thresholds and no idle gaps.
      write_csr(CSR_STEP_THRESHOLD, 15'd0);
      write_csr(CSR_CHANGE_THRESHOLD, 15'd0);
      settings_used++;
      idle_on = 1'b0;
      burst_samples = 99;
      for (int i = 0; i < burst_samples; i++) begin
         case (i % 3)
            0: queue_sample(0, 0, 0);
            1: queue_sample(100, 0, 0);
            default: queue_sample(300, 0, 0);
         endcase
      end
      wait_until_idle();

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         idle_on = (round != 2);
         xo = pick_offset();
         yo = pick_offset();
         zo = pick_offset();
         thr = pick_threshold(6000);
         chg = pick_threshold(2000);
         write_csr(CSR_X_OFFSET, {1'($urandom), 14'(xo)});
         write_csr(CSR_Y_OFFSET, {1'($urandom), 14'(yo)});
         write_csr(CSR_Z_OFFSET, {1'($urandom), 14'(zo)});
         write_csr(CSR_STEP_THRESHOLD, 15'(thr));
         write_csr(CSR_CHANGE_THRESHOLD, 15'(chg));
         settings_used++;
         queue_walk(ROUND_SAMPLES, xo, yo, zo, thr, chg);
         wait_until_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d samples and %0d checked results under %0d register settings.",
               samples_accepted, results_checked, settings_used);
      $display("Steps flagged: %0d; the step count wrapped %0d time(s).",
               steps_flagged, wrap_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out waiting for the block to finish.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
